@@ hw/rtl/sba_pkg.sv @@
// Shared types and constants for the stack bump allocator.
// Used by sba_mark_cell and stack_bump_allocator; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sba_pkg;

	localparam int unsigned MEM_BYTES_DEF  = 16777216;
	localparam int unsigned MARK_DEPTH_DEF = 64;
	localparam int unsigned RESERVED_BASE  = 32'h4000;
	localparam int unsigned ALIGN_MASK     = 31;
	localparam int unsigned OUT_W          = 25;
	localparam int unsigned CFG_W          = 7;

	typedef enum logic [1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_FREE   = 2'd1,
		KIND_INIT   = 2'd2,
		KIND_DEINIT = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOT_INIT = 2'd1,
		ST_NO_SPACE = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		logic push;
		logic pop;
	} stk_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/stack_bump_allocator.sv @@
// Stack bump allocator: pointer, request decode and a row of mark cells.
// Depends on sba_pkg and sba_mark_cell.
// The done strobe and the result are registered and follow start in the next cycle.
// Throughput: one transaction per cycle; busy stays low, the whole request
// is one add, compare and one shift of the mark-cell row.
// Reset: pointer at 0x4000, mark stack empty, not initialized, limit 0.
// The receiver cannot stall; done marks every result for exactly one cycle.
`timescale 1ns / 1ps
`default_nettype none

module stack_bump_allocator #(
	parameter int unsigned MEM_BYTES  = sba_pkg::MEM_BYTES_DEF,
	parameter int unsigned MARK_DEPTH = sba_pkg::MARK_DEPTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [sba_pkg::CFG_W-1:0]    cfg_data,
	input  wire logic                         start,
	input  wire logic [1:0]                   kind,
	input  wire logic [31:0]                  request_length,
	output logic                              busy,
	output logic                              done,
	output logic      [sba_pkg::OUT_W-1:0]    block_offset,
	output logic      [sba_pkg::OUT_W-1:0]    freed_length,
	output logic      [1:0]                   status
);

	localparam int unsigned PTR_W   = $clog2(MEM_BYTES + 1);
	localparam int unsigned DEPTH_W = $clog2(MARK_DEPTH + 1);
	localparam int unsigned CMP_W   = (DEPTH_W > sba_pkg::CFG_W) ? DEPTH_W : sba_pkg::CFG_W;

	logic [sba_pkg::CFG_W-1:0] cfg_q;
	logic [PTR_W-1:0]          next_free_q;
	logic [DEPTH_W-1:0]        depth_q;
	logic                      ready_q;
	logic                      done_q;
	logic [PTR_W-1:0]          offset_q;
	logic [PTR_W-1:0]          freed_q;
	sba_pkg::status_t          status_q;

	logic [32:0]               rounded;
	logic [PTR_W-1:0]          room;
	logic                      fits;
	logic                      room_to_push;
	logic [PTR_W-1:0]          top;
	logic [PTR_W-1:0]          cell_val [MARK_DEPTH];
	sba_pkg::stk_ctl_t         stk_ctl;

	logic [PTR_W-1:0]          next_free_d;
	logic [DEPTH_W-1:0]        depth_d;
	logic                      ready_d;
	logic [PTR_W-1:0]          offset_d;
	logic [PTR_W-1:0]          freed_d;
	sba_pkg::status_t          status_d;

	assign rounded = ({1'b0, request_length} + 33'(sba_pkg::ALIGN_MASK))
		& ~33'(sba_pkg::ALIGN_MASK);
	assign room    = PTR_W'(MEM_BYTES) - next_free_q;
	assign fits    = rounded <= 33'(room);
	assign room_to_push = (CMP_W'(depth_q) < CMP_W'(cfg_q))
		&& (depth_q < DEPTH_W'(MARK_DEPTH));
	assign top     = cell_val[0];

	always_comb begin
		next_free_d   = next_free_q;
		depth_d       = depth_q;
		ready_d       = ready_q;
		offset_d      = '0;
		freed_d       = '0;
		status_d      = sba_pkg::ST_OK;
		stk_ctl.push  = 1'b0;
		stk_ctl.pop   = 1'b0;
		if (start) begin
			unique case (sba_pkg::kind_t'(kind))
				sba_pkg::KIND_INIT: begin
					next_free_d = PTR_W'(sba_pkg::RESERVED_BASE);
					depth_d     = '0;
					ready_d     = 1'b1;
					offset_d    = PTR_W'(sba_pkg::RESERVED_BASE);
				end
				sba_pkg::KIND_DEINIT: begin
					ready_d = 1'b0;
				end
				sba_pkg::KIND_ALLOC: begin
					if (!ready_q) begin
						status_d = sba_pkg::ST_NOT_INIT;
					end else if (!fits) begin
						status_d = sba_pkg::ST_NO_SPACE;
					end else begin
						offset_d    = next_free_q;
						next_free_d = next_free_q + PTR_W'(rounded);
						if (room_to_push) begin
							stk_ctl.push = 1'b1;
							depth_d      = depth_q + 1'b1;
						end
					end
				end
				sba_pkg::KIND_FREE: begin
					if (!ready_q) begin
						status_d = sba_pkg::ST_NOT_INIT;
					end else if (depth_q == '0) begin
						status_d = sba_pkg::ST_EMPTY;
					end else begin
						stk_ctl.pop = 1'b1;
						depth_d     = depth_q - 1'b1;
						offset_d    = top;
						freed_d     = next_free_q - top;
						next_free_d = top;
					end
				end
				default: begin
					status_d = sba_pkg::ST_OK;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= '0;
			next_free_q <= PTR_W'(sba_pkg::RESERVED_BASE);
			depth_q     <= '0;
			ready_q     <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			next_free_q <= next_free_d;
			depth_q     <= depth_d;
			ready_q     <= ready_d;
			done_q      <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			offset_q <= offset_d;
			freed_q  <= freed_d;
			status_q <= status_d;
		end
	end

	for (genvar i = 0; i < MARK_DEPTH; i++) begin : g_cell
		logic [PTR_W-1:0] prev_val;
		logic [PTR_W-1:0] next_val;
		if (i == 0) begin : g_head
			assign prev_val = next_free_q;
		end else begin : g_body
			assign prev_val = cell_val[i-1];
		end
		if (i == MARK_DEPTH - 1) begin : g_tail
			assign next_val = '0;
		end else begin : g_link
			assign next_val = cell_val[i+1];
		end
		sba_mark_cell #(
			.W(PTR_W)
		) u_cell (
			.clk      (clk),
			.ctl      (stk_ctl),
			.from_prev(prev_val),
			.from_next(next_val),
			.value    (cell_val[i])
		);
	end

	assign busy         = 1'b0;
	assign done         = done_q;
	assign block_offset = sba_pkg::OUT_W'(offset_q);
	assign freed_length = sba_pkg::OUT_W'(freed_q);
	assign status       = status_q;

endmodule

`default_nettype wire

@@ hw/rtl/sba_mark_cell.sv @@
// One entry of the shifting mark stack.
// Depends on sba_pkg for the stack control struct.
`timescale 1ns / 1ps
`default_nettype none

module sba_mark_cell #(
	parameter int unsigned W = 25
) (
	input  wire logic             clk,
	input  wire sba_pkg::stk_ctl_t ctl,
	input  wire logic [W-1:0]     from_prev,
	input  wire logic [W-1:0]     from_next,
	output logic      [W-1:0]     value
);

	logic [W-1:0] value_q;

	// shift down on push, up on pop, hold otherwise
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			value_q <= from_prev;
		end else if (ctl.pop) begin
			value_q <= from_next;
		end
	end

	assign value = value_q;

endmodule

`default_nettype wire
